### rtl/mmp_pkg.sv
// Shared constants, types and helpers for the modular matrix power block.
`default_nettype none
package mmp_pkg;

	localparam int MAX_DIM_DEF = 64;

	// Residue arithmetic
	localparam int VW = 30;
	localparam int PW = 2 * VW;
	localparam logic [VW-1:0] PRIME = 30'd1000000007;
	localparam int NCELLS = VW;

	// Request and result codes
	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_COMPUTE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;
	localparam logic KIND_SUM   = 1'b0;
	localparam logic KIND_ENTRY = 1'b1;

	// Register word index
	localparam logic REG_MATRIX_SIZE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_BITSEL,
		ST_MUL,
		ST_MDRAIN,
		ST_MCOPY,
		ST_SQ,
		ST_SDRAIN,
		ST_SCOPY,
		ST_SHIFT,
		ST_CLEAR,
		ST_SUM,
		ST_SUMFIN,
		ST_READ,
		ST_OUTW
	} state_t;

	// Control that rides along the multiply-reduce chain
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// Sum of two residues, reduced
	function automatic logic [VW-1:0] addmod(input logic [VW-1:0] a, input logic [VW-1:0] b);
		logic [VW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PRIME})
			s = s - {1'b0, PRIME};
		return s[VW-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/modular_matrix_power.sv
// Top level of the modular matrix power block.
//
// Items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the request
// type. A load writes one base entry (reduced mod 1000000007). A
// compute raises the base matrix to the power walk_length-1 and returns the sum
// of all power entries; a read returns one power entry. Results leave on
// m_tvalid/m_tready/m_tdata/m_tuser through an output register; a stalled
// receiver holds the block in its final state, and loads and reads wait.
// The block accepts one item when idle. A compute sets the power store to the
// identity, then per exponent bit multiplies when the bit is set and squares,
// each pass drained and copied back from scratch; a MAX_DIM*MAX_DIM sweep then
// zeroes the base outside the active corner when any squaring ran, and a last
// pass sums the power entries. One multiply-reduce issues per cycle into a
// 32-stage chain (store read, multiplier, 30 reduction cells).
// Reset clears control state; matrix stores hold no reset value.
// matrix_size sits at APB byte address 0; pready is always high.
`default_nettype none
module modular_matrix_power #(
	parameter int MAX_DIM = mmp_pkg::MAX_DIM_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// Input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // row[5:0], col[11:6], entry_value[41:12], walk_length[72:42]
	input  wire logic [1:0]  s_tuser,  // req_type[1:0]
	// Result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // result_value[29:0]
	output logic [0:0]       m_tuser   // result_kind[0]
);
	import mmp_pkg::*;

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW    = 2 * IW;
	localparam int NW    = $clog2(MAX_DIM + 1);
	localparam int DEPTH = 1 << AW;

	// Input fields
	logic [5:0]    in_row;
	logic [5:0]    in_col;
	logic [VW-1:0] in_entry;
	logic [30:0]   in_walk;
	logic          in_acc;

	assign in_row   = s_tdata[5:0];
	assign in_col   = s_tdata[11:6];
	assign in_entry = s_tdata[41:12];
	assign in_walk  = s_tdata[72:42];
	assign in_acc   = s_tvalid && s_tready;

	// Configuration
	logic [6:0] matrix_size_q;
	logic [7:0] n8;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {25'd0, matrix_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= 7'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_SIZE) begin
			matrix_size_q <= pwdata[6:0];
		end
	end

	// Clamp size to the store
	always_comb begin
		if (matrix_size_q == 7'd0)
			n8 = 8'd1;
		else if ({1'b0, matrix_size_q} > 8'(MAX_DIM))
			n8 = 8'(MAX_DIM);
		else
			n8 = {1'b0, matrix_size_q};
	end

	// Stores
	logic [VW-1:0] base_mem  [DEPTH];
	logic [VW-1:0] power_mem [DEPTH];
	logic [VW-1:0] scr_mem   [DEPTH];

	logic          base_we, power_we;
	logic [AW-1:0] base_wa, power_wa, base_ra, base_rb, power_ra, scr_ra;
	logic [VW-1:0] base_wd, power_wd;
	logic [VW-1:0] base_rda, base_rdb, power_rd, scr_rd;

	logic          scr_we;
	logic [AW-1:0] scr_wa;
	logic [VW-1:0] scr_wd;

	always_ff @(posedge clk) begin
		if (base_we)
			base_mem[base_wa] <= base_wd;
		base_rda <= base_mem[base_ra];
		base_rdb <= base_mem[base_rb];
	end

	always_ff @(posedge clk) begin
		if (power_we)
			power_mem[power_wa] <= power_wd;
		power_rd <= power_mem[power_ra];
	end

	always_ff @(posedge clk) begin
		if (scr_we)
			scr_mem[scr_wa] <= scr_wd;
		scr_rd <= scr_mem[scr_ra];
	end

	// Sequencer state
	state_t        state_q, state_d;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [NW-1:0] pdim_q;
	logic [30:0]   exp_q;
	logic          squared_q;
	logic [VW-1:0] sum_q, rd_val_q;
	logic          rd_ok_q;
	logic          res_kind_q;
	logic          out_valid_q, out_kind_q;
	logic [VW-1:0] out_val_q;

	// Pipeline registers after the store reads
	mac_ctl_t      iss_ctl_s1;
	logic [AW-1:0] iss_addr_s1;
	logic          iss_sq_s1;
	logic          cp_valid_s1, cp_base_s1;
	logic [AW-1:0] cp_addr_s1;
	logic          sm_valid_s1;

	// Comb controls
	logic          cnt_clr, adv3, adv2;
	logic          mac_issue, cp_issue, sm_issue, out_load;
	logic [IW-1:0] lim;
	logic          i_last, j_last, k_last;
	logic          mac_idle;
	logic          load_ok, rd_ok;

	assign lim    = (state_q == ST_CLEAR) ? IW'(MAX_DIM - 1) : IW'(pdim_q - NW'(1));
	assign i_last = (i_q == lim);
	assign j_last = (j_q == lim);
	assign k_last = (k_q == lim);

	assign load_ok = ({2'b00, in_row} < 8'(MAX_DIM)) && ({2'b00, in_col} < 8'(MAX_DIM));
	assign rd_ok   = ({2'b00, in_row} < 8'(pdim_q)) && ({2'b00, in_col} < 8'(pdim_q));

	// Next state and controls
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cnt_clr   = 1'b0;
		adv3      = 1'b0;
		adv2      = 1'b0;
		mac_issue = 1'b0;
		cp_issue  = 1'b0;
		sm_issue  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cnt_clr  = 1'b1;
				if (in_acc) begin
					case (s_tuser)
						REQ_COMPUTE: state_d = ST_INIT;
						REQ_READ:    state_d = ST_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				adv2 = 1'b1;
				if (i_last && j_last)
					state_d = ST_BITSEL;
			end
			ST_BITSEL: begin
				cnt_clr = 1'b1;
				if (exp_q == 31'd0)
					state_d = squared_q ? ST_CLEAR : ST_SUM;
				else
					state_d = exp_q[0] ? ST_MUL : ST_SQ;
			end
			ST_MUL: begin
				adv3      = 1'b1;
				mac_issue = 1'b1;
				if (i_last && j_last && k_last)
					state_d = ST_MDRAIN;
			end
			ST_MDRAIN: begin
				cnt_clr = 1'b1;
				if (!iss_ctl_s1.valid && mac_idle)
					state_d = ST_MCOPY;
			end
			ST_MCOPY: begin
				adv2     = 1'b1;
				cp_issue = 1'b1;
				if (i_last && j_last)
					state_d = ST_SQ;
			end
			ST_SQ: begin
				adv3      = 1'b1;
				mac_issue = 1'b1;
				if (i_last && j_last && k_last)
					state_d = ST_SDRAIN;
			end
			ST_SDRAIN: begin
				cnt_clr = 1'b1;
				if (!iss_ctl_s1.valid && mac_idle)
					state_d = ST_SCOPY;
			end
			ST_SCOPY: begin
				adv2     = 1'b1;
				cp_issue = 1'b1;
				if (i_last && j_last)
					state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cnt_clr = 1'b1;
				state_d = ST_BITSEL;
			end
			ST_CLEAR: begin
				adv2 = 1'b1;
				if (i_last && j_last)
					state_d = ST_SUM;
			end
			ST_SUM: begin
				adv2     = 1'b1;
				sm_issue = 1'b1;
				if (i_last && j_last)
					state_d = ST_SUMFIN;
			end
			ST_SUMFIN: begin
				state_d = ST_OUTW;
			end
			ST_READ: begin
				state_d = ST_OUTW;
			end
			ST_OUTW: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			squared_q   <= 1'b0;
			pdim_q      <= '0;
			iss_ctl_s1  <= '0;
			cp_valid_s1 <= 1'b0;
			sm_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			iss_ctl_s1  <= '{valid: mac_issue, first: (k_q == '0), last: k_last};
			cp_valid_s1 <= cp_issue;
			sm_valid_s1 <= sm_issue;
			if (state_q == ST_IDLE && in_acc && s_tuser == REQ_COMPUTE) begin
				pdim_q    <= NW'(n8);
				exp_q     <= (in_walk == 31'd0) ? 31'd0 : (in_walk - 31'd1);
				squared_q <= 1'b0;
			end else if (state_q == ST_SHIFT) begin
				exp_q     <= exp_q >> 1;
				squared_q <= 1'b1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Index counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (cnt_clr) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (adv3 || adv2) begin
			if (adv3 && !k_last) begin
				k_q <= k_q + IW'(1);
			end else begin
				k_q <= '0;
				if (!j_last) begin
					j_q <= j_q + IW'(1);
				end else begin
					j_q <= '0;
					i_q <= i_last ? '0 : (i_q + IW'(1));
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		iss_addr_s1 <= {i_q, j_q};
		iss_sq_s1   <= (state_q == ST_SQ);
		cp_addr_s1  <= {i_q, j_q};
		cp_base_s1  <= (state_q == ST_SCOPY);
		if (state_q == ST_IDLE) begin
			rd_ok_q    <= rd_ok;
			res_kind_q <= (s_tuser == REQ_READ) ? KIND_ENTRY : KIND_SUM;
		end
		if (state_q == ST_INIT)
			sum_q <= '0;
		else if (sm_valid_s1)
			sum_q <= addmod(sum_q, power_rd);
		if (state_q == ST_READ)
			rd_val_q <= rd_ok_q ? power_rd : '0;
		if (out_load) begin
			out_kind_q <= res_kind_q;
			out_val_q  <= (res_kind_q == KIND_ENTRY) ? rd_val_q : sum_q;
		end
	end

	// Read addresses
	assign base_ra  = {i_q, k_q};
	assign base_rb  = {k_q, j_q};
	assign scr_ra   = {i_q, j_q};
	assign power_ra = (state_q == ST_IDLE) ? {IW'(in_row), IW'(in_col)} :
	                  (state_q == ST_SUM)  ? {i_q, j_q} : {i_q, k_q};

	// Base writes: load, copy after squaring, clearing sweep
	always_comb begin
		base_we = 1'b0;
		base_wa = {i_q, j_q};
		base_wd = '0;
		if (state_q == ST_IDLE && in_acc && s_tuser == REQ_LOAD) begin
			base_we = load_ok;
			base_wa = {IW'(in_row), IW'(in_col)};
			base_wd = (in_entry >= PRIME) ? (in_entry - PRIME) : in_entry;
		end else if (cp_valid_s1 && cp_base_s1) begin
			base_we = 1'b1;
			base_wa = cp_addr_s1;
			base_wd = scr_rd;
		end else if (state_q == ST_CLEAR) begin
			base_we = (NW'(i_q) >= pdim_q) || (NW'(j_q) >= pdim_q);
		end
	end

	// Power writes: identity setup, copy after multiply
	always_comb begin
		power_we = 1'b0;
		power_wa = {i_q, j_q};
		power_wd = '0;
		if (state_q == ST_INIT) begin
			power_we = 1'b1;
			power_wd = (i_q == j_q) ? VW'(1) : '0;
		end else if (cp_valid_s1 && !cp_base_s1) begin
			power_we = 1'b1;
			power_wa = cp_addr_s1;
			power_wd = scr_rd;
		end
	end

	// Multiply-reduce chain
	mmp_mac #(
		.AW(AW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (iss_ctl_s1),
		.addr_in(iss_addr_s1),
		.a_in   (iss_sq_s1 ? base_rda : power_rd),
		.b_in   (base_rdb),
		.wr_en  (scr_we),
		.wr_addr(scr_wa),
		.wr_data(scr_wd),
		.idle   (mac_idle)
	);

	// Result port
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_val_q};
	assign m_tuser  = out_kind_q;

endmodule
`default_nettype wire

### rtl/mmp_red_cell.sv
// One cell of the reduction chain: subtract a shifted copy of the prime when it fits.
`default_nettype none
module mmp_red_cell #(
	parameter int AW    = 12,
	parameter int SHIFT = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mmp_pkg::mac_ctl_t     ctl_in,
	input  wire logic [AW-1:0]         addr_in,
	input  wire logic [mmp_pkg::PW-1:0] val_in,
	output mmp_pkg::mac_ctl_t          ctl_out,
	output logic [AW-1:0]              addr_out,
	output logic [mmp_pkg::PW-1:0]     val_out
);
	import mmp_pkg::*;

	localparam logic [PW-1:0] SUB = PW'(PRIME) << SHIFT;

	logic [PW-1:0] val_c;

	// Conditional subtract
	always_comb begin
		val_c = (val_in >= SUB) ? (val_in - SUB) : val_in;
	end

	// Hand control to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	// Hand payload to the next cell
	always_ff @(posedge clk) begin
		addr_out <= addr_in;
		val_out  <= val_c;
	end

endmodule
`default_nettype wire

### rtl/mmp_mac.sv
// Multiply, reduction chain of cells and dot-product accumulator.
`default_nettype none
module mmp_mac #(
	parameter int AW = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mmp_pkg::mac_ctl_t     ctl_in,
	input  wire logic [AW-1:0]         addr_in,
	input  wire logic [mmp_pkg::VW-1:0] a_in,
	input  wire logic [mmp_pkg::VW-1:0] b_in,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [mmp_pkg::VW-1:0]     wr_data,
	output logic                       idle
);
	import mmp_pkg::*;

	mac_ctl_t      mul_ctl_s1;
	logic [AW-1:0] mul_addr_s1;
	logic [PW-1:0] mul_val_s1;
	mac_ctl_t      ctl_c  [NCELLS+1];
	logic [AW-1:0] addr_c [NCELLS+1];
	logic [PW-1:0] val_c  [NCELLS+1];
	logic [VW-1:0] acc_q;
	logic [VW-1:0] acc_c;

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_ctl_s1 <= '0;
		end else begin
			mul_ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		mul_addr_s1 <= addr_in;
		mul_val_s1  <= PW'(a_in) * PW'(b_in);
	end

	assign ctl_c[0]  = mul_ctl_s1;
	assign addr_c[0] = mul_addr_s1;
	assign val_c[0]  = mul_val_s1;

	// Chain of reduction cells, largest multiple of the prime first
	for (genvar g = 0; g < NCELLS; g++) begin : g_cell
		mmp_red_cell #(
			.AW   (AW),
			.SHIFT(NCELLS - 1 - g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[g]),
			.addr_in (addr_c[g]),
			.val_in  (val_c[g]),
			.ctl_out (ctl_c[g+1]),
			.addr_out(addr_c[g+1]),
			.val_out (val_c[g+1])
		);
	end

	// Accumulate one dot product
	always_comb begin
		acc_c = addmod(ctl_c[NCELLS].first ? '0 : acc_q, val_c[NCELLS][VW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl_c[NCELLS].valid)
			acc_q <= acc_c;
	end

	assign wr_en   = ctl_c[NCELLS].valid && ctl_c[NCELLS].last;
	assign wr_addr = addr_c[NCELLS];
	assign wr_data = acc_c;

	// Flag an empty chain
	always_comb begin
		idle = 1'b1;
		for (int c = 0; c <= NCELLS; c++)
			if (ctl_c[c].valid)
				idle = 1'b0;
	end

endmodule
`default_nettype wire

### rtl/mmp_checker.sv
// Port-level checker for the modular matrix power block, bound to the top level.
`default_nettype none
module mmp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [0:0]  m_tuser
);
	import mmp_pkg::*;

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Results are reduced residues
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[29:0] < PRIME) && (m_tdata[31:30] == 2'b00))
		else $error("result out of range");

	// Compute and read items occupy the block
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_COMPUTE || s_tuser == REQ_READ)
		|=> !s_tready)
		else $error("item taken while busy");

	// A read keeps s_tready low through ST_READ and into ST_OUTW
	a_rd_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_READ |=> ##1 !s_tready)
		else $error("read finished too early");

endmodule

bind modular_matrix_power mmp_checker u_mmp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire
